### src/ldfw_pkg.sv
// shared types, constants and the power-of-ten tables for the lcd decimal field writer
// no dependencies

package ldfw_pkg;

    localparam int MAX_DIGITS_DEF = 5;
    localparam int ROW_W          = 3;
    localparam int COL_W          = 6;
    localparam int NUM_W          = 18;
    localparam int FW_W           = 3;
    localparam int BYTE_W         = 8;

    localparam logic [2:0] SEL_ADDR  = 3'd0;
    localparam logic [2:0] SEL_MINUS = 3'd1;
    localparam logic [2:0] SEL_SPACE = 3'd2;
    localparam logic [2:0] SEL_QUOT  = 3'd3;
    localparam logic [2:0] SEL_MAG   = 3'd4;

    localparam logic [BYTE_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CMD_ADDR   = 8'h80;

    typedef struct packed {
        logic       load;
        logic       emit;
        logic [2:0] sel;
        logic       last;
        logic       pos_inc;
        logic       div_init;
        logic       div_step;
    } ldfw_cmd_t;

    typedef struct packed {
        logic out_free;
        logic neg;
        logic space_ok;
        logic digits_left;
        logic div_last;
    } ldfw_sts_t;

    function automatic logic [31:0] pow10_f(input logic [3:0] k);
        logic [31:0] p;
        case (k)
            4'd0:    p = 32'd1;
            4'd1:    p = 32'd10;
            4'd2:    p = 32'd100;
            4'd3:    p = 32'd1000;
            4'd4:    p = 32'd10000;
            4'd5:    p = 32'd100000;
            4'd6:    p = 32'd1000000;
            4'd7:    p = 32'd10000000;
            4'd8:    p = 32'd100000000;
            4'd9:    p = 32'd1000000000;
            default: p = 32'd1;
        endcase
        return p;
    endfunction

    // ceil(2^s / 10^k), exact quotient for any 18-bit magnitude
    function automatic logic [NUM_W:0] recip_f(input logic [3:0] k);
        logic [NUM_W:0] m;
        case (k)
            4'd0:    m = 19'd262144;
            4'd1:    m = 19'd419431;
            4'd2:    m = 19'd335545;
            4'd3:    m = 19'd268436;
            4'd4:    m = 19'd429497;
            4'd5:    m = 19'd343598;
            4'd6:    m = 19'd274878;
            4'd7:    m = 19'd439805;
            4'd8:    m = 19'd351844;
            4'd9:    m = 19'd281475;
            default: m = 19'd262144;
        endcase
        return m;
    endfunction

    // s for the reciprocal of 10^k
    function automatic logic [5:0] rshift_f(input logic [3:0] k);
        logic [5:0] s;
        case (k)
            4'd0:    s = 6'd18;
            4'd1:    s = 6'd22;
            4'd2:    s = 6'd25;
            4'd3:    s = 6'd28;
            4'd4:    s = 6'd32;
            4'd5:    s = 6'd35;
            4'd6:    s = 6'd38;
            4'd7:    s = 6'd42;
            4'd8:    s = 6'd45;
            4'd9:    s = 6'd48;
            default: s = 6'd18;
        endcase
        return s;
    endfunction

endpackage

### src/ldfw_ctrl.sv
// sequencer for the lcd decimal field writer: address, sign, spaces, digits
// depends on ldfw_pkg

module ldfw_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  ldfw_pkg::ldfw_sts_t sts,
    output ldfw_pkg::ldfw_cmd_t cmd
);
    import ldfw_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ADDR  = 3'd1;
    localparam logic [2:0] S_SIGN  = 3'd2;
    localparam logic [2:0] S_LEAD  = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_DOUT  = 3'd5;
    localparam logic [2:0] S_DNEXT = 3'd6;
    localparam logic [2:0] S_FINAL = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_ADDR;
                end
            end
            S_ADDR:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.sel    = SEL_ADDR;
                    state_next = sts.neg ? S_SIGN : S_LEAD;
                end
            end
            S_SIGN:
            begin
                if (sts.out_free)
                begin
                    cmd.emit    = 1'b1;
                    cmd.sel     = SEL_MINUS;
                    cmd.pos_inc = 1'b1;
                    state_next  = S_LEAD;
                end
            end
            S_LEAD:
            begin
                if (sts.space_ok)
                begin
                    if (sts.out_free)
                    begin
                        cmd.emit    = 1'b1;
                        cmd.sel     = SEL_SPACE;
                        cmd.pos_inc = 1'b1;
                    end
                end
                else if (sts.digits_left)
                begin
                    cmd.div_init = 1'b1;
                    state_next   = S_DIV;
                end
                else
                begin
                    state_next = S_FINAL;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = S_DOUT;
                end
            end
            S_DOUT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit    = 1'b1;
                    cmd.sel     = SEL_QUOT;
                    cmd.pos_inc = 1'b1;
                    state_next  = S_DNEXT;
                end
            end
            S_DNEXT:
            begin
                if (sts.digits_left)
                begin
                    cmd.div_init = 1'b1;
                    state_next   = S_DIV;
                end
                else
                begin
                    state_next = S_FINAL;
                end
            end
            S_FINAL:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.sel    = SEL_MAG;
                    cmd.last   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### src/ldfw_dp.sv
// datapath: address byte, magnitude, position counter, reciprocal divider, output register
// depends on ldfw_pkg

module ldfw_dp #(
    parameter int MAX_DIGITS = ldfw_pkg::MAX_DIGITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [ldfw_pkg::ROW_W-1:0]          row,
    input  logic [ldfw_pkg::COL_W-1:0]          column,
    input  logic signed [ldfw_pkg::NUM_W-1:0]   number,
    input  logic [ldfw_pkg::FW_W-1:0]           field_width,
    input  ldfw_pkg::ldfw_cmd_t                 cmd,
    output ldfw_pkg::ldfw_sts_t                 sts,
    input  logic                                out_stall,
    output logic                                out_valid,
    output logic                                is_command,
    output logic [ldfw_pkg::BYTE_W-1:0]         lcd_byte,
    output logic                                last
);
    import ldfw_pkg::*;

    localparam int IW  = $clog2(MAX_DIGITS + 1);
    localparam int CW  = (IW > FW_W) ? IW : FW_W;
    localparam int PW  = $clog2(10 ** (MAX_DIGITS - 1) + 1);
    localparam int SW  = PW + NUM_W;
    localparam int RW  = NUM_W + 1;
    localparam int PRW = NUM_W + RW;

    logic [BYTE_W-1:0] addr_reg;
    logic [BYTE_W-1:0] addr_next;
    logic [NUM_W-1:0]  mag_reg;
    logic [NUM_W-1:0]  mag_next;
    logic              neg_reg;
    logic              neg_next;
    logic [IW-1:0]     pos_reg;
    logic [IW-1:0]     pos_next;
    logic [BYTE_W-1:0] q_reg;
    logic [BYTE_W-1:0] q_next;
    logic              k_reg;
    logic              k_next;
    logic [PRW-1:0]    prod_reg;
    logic [PRW-1:0]    prod_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              is_command_reg;
    logic              is_command_next;
    logic [BYTE_W-1:0] lcd_byte_reg;
    logic [BYTE_W-1:0] lcd_byte_next;
    logic              last_reg;
    logic              last_next;

    logic [BYTE_W-1:0] offset;
    logic [CW-1:0]     fw_ext;
    logic [CW-1:0]     fw_clamp;
    logic [NUM_W-1:0]  num_u;
    logic [NUM_W-1:0]  mag_in;
    logic [3:0]        p_idx;
    logic [PW-1:0]     p_cur;
    logic [RW-1:0]     recip;
    logic [5:0]        rsh;
    logic [NUM_W-1:0]  quo;
    logic [SW-1:0]     qp;
    logic              digits_left;
    logic              out_free;
    logic [BYTE_W-1:0] byte_sel;

    always_comb
    begin
        case (row)
            3'd2:    offset = 8'h40;
            3'd3:    offset = 8'h14;
            3'd4:    offset = 8'h54;
            default: offset = 8'h00;
        endcase
        addr_next = BYTE_W'(CMD_ADDR + offset + {2'b00, column} - 8'd1);

        fw_ext = CW'(field_width);
        if (fw_ext == '0)
        begin
            fw_clamp = CW'(1);
        end
        else if (fw_ext > CW'(MAX_DIGITS))
        begin
            fw_clamp = CW'(MAX_DIGITS);
        end
        else
        begin
            fw_clamp = fw_ext;
        end

        num_u  = number;
        mag_in = number[NUM_W-1] ? (~num_u + 1'b1) : num_u;
    end

    // power of ten for the current position and its reciprocal
    assign p_idx       = 4'(MAX_DIGITS - 1) - 4'(pos_reg);
    assign p_cur       = PW'(pow10_f(p_idx));
    assign recip       = recip_f(p_idx);
    assign rsh         = rshift_f(p_idx);
    assign quo         = NUM_W'(prod_reg >> rsh);
    assign qp          = SW'(quo) * SW'(p_cur);
    assign digits_left = pos_reg < IW'(MAX_DIGITS - 1);
    assign out_free    = !out_valid_reg || !out_stall;

    assign sts.out_free    = out_free;
    assign sts.neg         = neg_reg;
    assign sts.space_ok    = digits_left && (SW'(mag_reg) < SW'(p_cur));
    assign sts.digits_left = digits_left;
    assign sts.div_last    = !k_reg;

    always_comb
    begin
        case (cmd.sel)
            SEL_ADDR:  byte_sel = addr_reg;
            SEL_MINUS: byte_sel = CHAR_MINUS;
            SEL_SPACE: byte_sel = CHAR_SPACE;
            SEL_QUOT:  byte_sel = CHAR_ZERO + q_reg;
            SEL_MAG:   byte_sel = CHAR_ZERO + mag_reg[BYTE_W-1:0];
            default:   byte_sel = CHAR_SPACE;
        endcase
    end

    always_comb
    begin
        mag_next        = mag_reg;
        neg_next        = neg_reg;
        pos_next        = pos_reg;
        q_next          = q_reg;
        k_next          = k_reg;
        prod_next       = prod_reg;
        out_valid_next  = out_valid_reg;
        is_command_next = is_command_reg;
        lcd_byte_next   = lcd_byte_reg;
        last_next       = last_reg;

        if (cmd.load)
        begin
            mag_next   = mag_in;
            neg_next   = number[NUM_W-1];
            pos_next   = IW'(CW'(MAX_DIGITS) - fw_clamp);
        end

        if (cmd.pos_inc)
        begin
            pos_next = pos_reg + 1'b1;
        end

        if (cmd.div_init)
        begin
            k_next = 1'b1;
        end

        // multiply by the reciprocal, then take the quotient and remainder
        if (cmd.div_step)
        begin
            if (k_reg)
            begin
                prod_next = PRW'(mag_reg) * PRW'(recip);
            end
            else
            begin
                mag_next = mag_reg - qp[NUM_W-1:0];
                q_next   = quo[BYTE_W-1:0];
            end
            k_next = 1'b0;
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.emit)
        begin
            out_valid_next  = 1'b1;
            is_command_next = (cmd.sel == SEL_ADDR);
            lcd_byte_next   = byte_sel;
            last_next       = cmd.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            addr_reg <= addr_next;
        end
        mag_reg        <= mag_next;
        neg_reg        <= neg_next;
        pos_reg        <= pos_next;
        q_reg          <= q_next;
        k_reg          <= k_next;
        prod_reg       <= prod_next;
        is_command_reg <= is_command_next;
        lcd_byte_reg   <= lcd_byte_next;
        last_reg       <= last_next;
    end

    assign out_valid  = out_valid_reg;
    assign is_command = is_command_reg;
    assign lcd_byte   = lcd_byte_reg;
    assign last       = last_reg;

endmodule

### src/lcd_decimal_field_writer.sv
// top level of the lcd decimal field writer: sequencer plus datapath
// depends on ldfw_pkg, ldfw_ctrl, ldfw_dp
//
// channel | direction | handshake          | payload
// in      | input     | in_valid/in_stall  | row, column, number, field_width
// out     | output    | out_valid/out_stall| is_command, lcd_byte, last
//
// one request at a time; a stalled out holds the sequencer on its next byte
// the request is accepted and the address byte sent, then the sign and each space are sent;
// each digit but the last takes a reciprocal multiply, a remainder, its output and the
// setup of the next, and the last digit is sent from the magnitude that remains
// rst_n clears the sequencer and output valid; no clearing pass
// the last byte may wait in the output register while the next request is taken

module lcd_decimal_field_writer #(
    parameter int MAX_DIGITS = ldfw_pkg::MAX_DIGITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [ldfw_pkg::ROW_W-1:0]        row,
    input  logic [ldfw_pkg::COL_W-1:0]        column,
    input  logic signed [ldfw_pkg::NUM_W-1:0] number,
    input  logic [ldfw_pkg::FW_W-1:0]         field_width,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              is_command,
    output logic [ldfw_pkg::BYTE_W-1:0]       lcd_byte,
    output logic                              last
);
    import ldfw_pkg::*;

    ldfw_cmd_t cmd;
    ldfw_sts_t sts;

    ldfw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    ldfw_dp #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .row         (row),
        .column      (column),
        .number      (number),
        .field_width (field_width),
        .cmd         (cmd),
        .sts         (sts),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .is_command  (is_command),
        .lcd_byte    (lcd_byte),
        .last        (last)
    );

endmodule

### src/ldfw_checker.sv
// port-level checks for the lcd decimal field writer, bound to the top level
// depends on ldfw_pkg and lcd_decimal_field_writer

module ldfw_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_stall,
    input logic [ldfw_pkg::ROW_W-1:0]        row,
    input logic [ldfw_pkg::COL_W-1:0]        column,
    input logic signed [ldfw_pkg::NUM_W-1:0] number,
    input logic [ldfw_pkg::FW_W-1:0]         field_width,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic                              is_command,
    input logic [ldfw_pkg::BYTE_W-1:0]       lcd_byte,
    input logic                              last
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(lcd_byte) && $stable(last)
            && $stable(is_command))
        else $error("output byte changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request taken while another is in progress");

    a_cmd_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_command |-> !last)
        else $error("address command marked as final byte");

    a_idle_holds_last: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall && out_valid |-> last && !is_command)
        else $error("ready for a request with an unfinished sequence pending");

endmodule

bind lcd_decimal_field_writer ldfw_checker u_ldfw_checker (.*);
